>>> hw/rtl/drive_direction_throttle_ctrl_macros.svh
// Assertion macros shared by the drive direction and throttle control RTL.
// Depends on nothing; the checks compile away when SYNTHESIS is defined.
`ifndef DRIVE_DIRECTION_THROTTLE_CTRL_MACROS_SVH
`define DRIVE_DIRECTION_THROTTLE_CTRL_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every clock edge outside reset.
`define DDTC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ddtc: same-cycle check failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define DDTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ddtc: next-cycle check failed");

`else

`define DDTC_ASSERT_NOW(label, clk, rst, ante, cons)
`define DDTC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/ddtc_pkg.sv
// Types and constants of the drive direction and throttle control block.
// Depends on nothing; imported by the pulse width unit and the top level.
package ddtc_pkg;

   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int LEVEL_BITS     = 12;
   localparam int COUNT_BITS     = 8;
   localparam int QUOT_BITS      = 11;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_REV_LIMIT      = 3'd0,
      REG_RPM_MESSAGE_ID = 3'd1,
      REG_RAMP_STEP      = 3'd2,
      REG_PULSE_OFFSET   = 3'd3,
      REG_PULSE_MAX      = 3'd4,
      REG_DEBOUNCE_TICKS = 3'd5
   } csr_index_type;

   localparam logic [15:0] REV_LIMIT_RESET      = 16'd5000;
   localparam logic [10:0] RPM_MESSAGE_ID_RESET = 11'h610;
   localparam logic [11:0] RAMP_STEP_RESET      = 12'd41;
   localparam logic [11:0] PULSE_OFFSET_RESET   = 12'd300;
   localparam logic [11:0] PULSE_MAX_RESET      = 12'd2500;
   localparam logic [7:0]  DEBOUNCE_TICKS_RESET = 8'd3;

   localparam logic [9:0]            PULSE_SPAN = 10'd1000;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX  = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

endpackage

>>> hw/rtl/ddtc_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on nothing; widths of the throttle samples follow SAMPLE_BITS.
interface ddtc_req_if #(parameter int SAMPLE_BITS = 12);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] throttle_a;
   logic [SAMPLE_BITS-1:0] throttle_b;
   logic                   fwd_switch;
   logic                   bwd_switch;
   logic                   frame_valid;
   logic [10:0]            frame_id;
   logic [7:0]             frame_byte0;
   logic [7:0]             frame_byte1;

   modport source (output valid, throttle_a, throttle_b, fwd_switch, bwd_switch,
                   frame_valid, frame_id, frame_byte0, frame_byte1, input ready);
   modport sink (input valid, throttle_a, throttle_b, fwd_switch, bwd_switch,
                 frame_valid, frame_id, frame_byte0, frame_byte1, output ready);
endinterface

interface ddtc_rsp_if;
   logic        valid;
   logic        ready;
   logic        fwd_drive_en;
   logic        rev_drive_en;
   logic [11:0] pulse_width_us;
   logic [11:0] motor_drive;
   logic        rev_limited;

   modport source (output valid, fwd_drive_en, rev_drive_en, pulse_width_us, motor_drive,
                   rev_limited, input ready);
   modport sink (input valid, fwd_drive_en, rev_drive_en, pulse_width_us, motor_drive,
                 rev_limited, output ready);
endinterface

>>> hw/rtl/ddtc_pulse.sv
// PWM pulse width: offset + floor(1000*sum / (2^SAMPLE_BITS - 1)), clamped.
// Depends on ddtc_pkg; purely combinational, used by the top level.
module ddtc_pulse import ddtc_pkg::*; #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic [SAMPLE_BITS:0]   sum,
   input  logic [LEVEL_BITS-1:0]  pulse_offset,
   input  logic [LEVEL_BITS-1:0]  pulse_max,
   output logic [LEVEL_BITS-1:0]  pulse_width
);
   localparam int XW = SAMPLE_BITS + 11;
   localparam int RW = ((SAMPLE_BITS > QUOT_BITS) ? SAMPLE_BITS : QUOT_BITS) + 1;
   localparam int QW = RW - SAMPLE_BITS;
   localparam logic [SAMPLE_BITS:0] DIVISOR = {1'b0, {SAMPLE_BITS{1'b1}}};

   logic [XW-1:0]            scaled;
   logic [QUOT_BITS-1:0]     quot_hi;
   logic [RW-1:0]            rem_one;
   logic [QW-1:0]            quot_mid;
   logic [SAMPLE_BITS:0]     rem_two;
   logic                     quot_lo;
   logic [QUOT_BITS-1:0]     quot;
   logic [LEVEL_BITS:0]      raw;

   // Division by 2^n-1 by folding: x = q*2^n + r equals q*(2^n-1) + (r+q).
   // Two folds leave a remainder below twice the divisor.
   always_comb begin
      scaled   = XW'(sum) * XW'(PULSE_SPAN);
      quot_hi  = QUOT_BITS'(scaled >> SAMPLE_BITS);
      rem_one  = RW'(scaled[SAMPLE_BITS-1:0]) + RW'(quot_hi);
      quot_mid = QW'(rem_one >> SAMPLE_BITS);
      rem_two  = (SAMPLE_BITS+1)'(rem_one[SAMPLE_BITS-1:0]) + (SAMPLE_BITS+1)'(quot_mid);
      quot_lo  = (rem_two >= DIVISOR);
      quot     = quot_hi + QUOT_BITS'(quot_mid) + QUOT_BITS'(quot_lo);
      raw      = {1'b0, pulse_offset} + (LEVEL_BITS+1)'(quot);
      if (raw > {1'b0, pulse_max}) begin
         pulse_width = pulse_max;
      end else begin
         pulse_width = raw[LEVEL_BITS-1:0];
      end
   end
endmodule

>>> hw/rtl/drive_direction_throttle_ctrl.sv
// Drive direction, throttle pulse and drive level control, one word per tick.
// A request word accepted into the input register moves on to the response
// register when that is free. Throughput: one word per cycle when not stalled.
// Reset (synchronous, active high) loads the register defaults, clears the
// direction latch, debounce counters and ramp level, and empties both stages.
module drive_direction_throttle_ctrl import ddtc_pkg::*; #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   ddtc_req_if.sink                   req_chan,
   ddtc_rsp_if.source                 rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wdata
);
`include "drive_direction_throttle_ctrl_macros.svh"

   // Configuration registers
   logic [15:0]           rev_limit_ff;
   logic [10:0]           rpm_message_id_ff;
   logic [LEVEL_BITS-1:0] ramp_step_ff;
   logic [LEVEL_BITS-1:0] pulse_offset_ff;
   logic [LEVEL_BITS-1:0] pulse_max_ff;
   logic [COUNT_BITS-1:0] debounce_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rev_limit_ff      <= REV_LIMIT_RESET;
         rpm_message_id_ff <= RPM_MESSAGE_ID_RESET;
         ramp_step_ff      <= RAMP_STEP_RESET;
         pulse_offset_ff   <= PULSE_OFFSET_RESET;
         pulse_max_ff      <= PULSE_MAX_RESET;
         debounce_ticks_ff <= DEBOUNCE_TICKS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            REG_REV_LIMIT:      rev_limit_ff      <= csr_wdata;
            REG_RPM_MESSAGE_ID: rpm_message_id_ff <= csr_wdata[10:0];
            REG_RAMP_STEP:      ramp_step_ff      <= csr_wdata[LEVEL_BITS-1:0];
            REG_PULSE_OFFSET:   pulse_offset_ff   <= csr_wdata[LEVEL_BITS-1:0];
            REG_PULSE_MAX:      pulse_max_ff      <= csr_wdata[LEVEL_BITS-1:0];
            REG_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Input register
   logic                   s1_valid_ff;
   logic [SAMPLE_BITS-1:0] s1_a_ff;
   logic [SAMPLE_BITS-1:0] s1_b_ff;
   logic                   s1_sf_ff;
   logic                   s1_sb_ff;
   logic                   s1_limited_ff;
   logic                   advance;
   logic                   req_take;

   assign advance          = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready   = !s1_valid_ff || advance;
   assign req_take         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   // Rpm compare at input; the user must write the limit only while idle (no check).
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_a_ff       <= req_chan.throttle_a;
         s1_b_ff       <= req_chan.throttle_b;
         s1_sf_ff      <= req_chan.fwd_switch;
         s1_sb_ff      <= req_chan.bwd_switch;
         s1_limited_ff <= req_chan.frame_valid
                          && (req_chan.frame_id == rpm_message_id_ff)
                          && ({req_chan.frame_byte1, req_chan.frame_byte0} >= rev_limit_ff);
      end
   end

   // Control state
   logic                  dir_fwd_ff, dir_fwd_in;
   logic                  dir_rev_ff, dir_rev_in;
   logic                  await_fwd_ff, await_fwd_in;
   logic                  await_bwd_ff, await_bwd_in;
   logic                  armed_fwd_ff, armed_fwd_in;
   logic                  armed_bwd_ff, armed_bwd_in;
   logic [COUNT_BITS-1:0] count_fwd_ff, count_fwd_in;
   logic [COUNT_BITS-1:0] count_bwd_ff, count_bwd_in;
   logic [LEVEL_BITS-1:0] ramp_ff, ramp_in;
   logic                  fwd_en;
   logic                  bwd_en;
   logic                  dir_off;
   logic                  dir_both;
   logic [LEVEL_BITS:0]   ramp_sum;
   logic [LEVEL_BITS-1:0] drive;

   logic [SAMPLE_BITS:0]  s1_sum;
   logic [LEVEL_BITS-1:0] avg;
   logic [LEVEL_BITS-1:0] pulse_width;

   assign s1_sum = {1'b0, s1_a_ff} + {1'b0, s1_b_ff};

   generate
      if (SAMPLE_BITS >= LEVEL_BITS) begin : g_avg_down
         assign avg = s1_sum[SAMPLE_BITS -: LEVEL_BITS];
      end else begin : g_avg_up
         assign avg = {s1_sum[SAMPLE_BITS:1], {(LEVEL_BITS-SAMPLE_BITS){1'b0}}};
      end
   endgenerate

   ddtc_pulse #(.SAMPLE_BITS(SAMPLE_BITS)) u_pulse (
      .sum          (s1_sum),
      .pulse_offset (pulse_offset_ff),
      .pulse_max    (pulse_max_ff),
      .pulse_width  (pulse_width)
   );

   always_comb begin
      dir_fwd_in   = dir_fwd_ff;
      dir_rev_in   = dir_rev_ff;
      await_fwd_in = await_fwd_ff;
      await_bwd_in = await_bwd_ff;
      armed_fwd_in = armed_fwd_ff;
      armed_bwd_in = armed_bwd_ff;
      count_fwd_in = count_fwd_ff;
      count_bwd_in = count_bwd_ff;
      ramp_in      = ramp_ff;
      dir_off      = !dir_fwd_ff && !dir_rev_ff;
      dir_both     = dir_fwd_ff && dir_rev_ff;
      fwd_en       = dir_fwd_ff && !dir_rev_ff;
      bwd_en       = dir_rev_ff && !dir_fwd_ff;

      // Re-arming: the forward switch has priority over the backward one.
      if (await_fwd_ff) begin
         if (!s1_sf_ff) begin
            armed_fwd_in = 1'b1;
            await_fwd_in = 1'b0;
         end
      end else if (await_bwd_ff) begin
         if (!s1_sb_ff) begin
            armed_bwd_in = 1'b1;
            await_bwd_in = 1'b0;
         end
      end

      if (s1_sf_ff) begin
         count_bwd_in = '0;
         count_fwd_in = (count_fwd_ff == COUNT_MAX) ? COUNT_MAX : count_fwd_ff + 1'b1;
         await_fwd_in = 1'b1;
         if (armed_fwd_in && (count_fwd_in > debounce_ticks_ff) && !dir_both) begin
            dir_fwd_in   = dir_off;
            dir_rev_in   = 1'b0;
            armed_fwd_in = 1'b0;
         end
      end else if (s1_sb_ff) begin
         count_fwd_in = '0;
         count_bwd_in = (count_bwd_ff == COUNT_MAX) ? COUNT_MAX : count_bwd_ff + 1'b1;
         await_bwd_in = 1'b1;
         if (armed_bwd_in && (count_bwd_in > debounce_ticks_ff) && !dir_both) begin
            dir_fwd_in   = 1'b0;
            dir_rev_in   = dir_off;
            armed_bwd_in = 1'b0;
         end
      end else begin
         count_fwd_in = '0;
         count_bwd_in = '0;
      end

      // Ramp up by the step toward the average, follow it down at once.
      ramp_sum = {1'b0, ramp_ff} + {1'b0, ramp_step_ff};
      if (s1_limited_ff) begin
         drive = '0;
      end else if (avg > ramp_ff) begin
         ramp_in = ramp_sum[LEVEL_BITS] ? LEVEL_MAX : ramp_sum[LEVEL_BITS-1:0];
         drive   = ramp_in;
      end else begin
         ramp_in = avg;
         drive   = avg;
      end
   end

   logic step;
   assign step = s1_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_fwd_ff   <= 1'b0;
         dir_rev_ff   <= 1'b0;
         await_fwd_ff <= 1'b1;
         await_bwd_ff <= 1'b1;
         armed_fwd_ff <= 1'b0;
         armed_bwd_ff <= 1'b0;
         count_fwd_ff <= '0;
         count_bwd_ff <= '0;
         ramp_ff      <= '0;
      end else if (step) begin
         dir_fwd_ff   <= dir_fwd_in;
         dir_rev_ff   <= dir_rev_in;
         await_fwd_ff <= await_fwd_in;
         await_bwd_ff <= await_bwd_in;
         armed_fwd_ff <= armed_fwd_in;
         armed_bwd_ff <= armed_bwd_in;
         count_fwd_ff <= count_fwd_in;
         count_bwd_ff <= count_bwd_in;
         ramp_ff      <= ramp_in;
      end
   end

   // Response register
   logic                  rsp_valid_ff;
   logic                  rsp_fwd_ff;
   logic                  rsp_bwd_ff;
   logic [LEVEL_BITS-1:0] rsp_pulse_ff;
   logic [LEVEL_BITS-1:0] rsp_drive_ff;
   logic                  rsp_limited_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_fwd_ff     <= fwd_en;
         rsp_bwd_ff     <= bwd_en;
         rsp_pulse_ff   <= pulse_width;
         rsp_drive_ff   <= drive;
         rsp_limited_ff <= s1_limited_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.fwd_drive_en   = rsp_fwd_ff;
   assign rsp_chan.rev_drive_en   = rsp_bwd_ff;
   assign rsp_chan.pulse_width_us = rsp_pulse_ff;
   assign rsp_chan.motor_drive    = rsp_drive_ff;
   assign rsp_chan.rev_limited    = rsp_limited_ff;

   `DDTC_ASSERT_NOW(a_dir_exclusive, clock, reset, 1'b1, !(dir_fwd_ff && dir_rev_ff))
   `DDTC_ASSERT_NOW(a_enables_exclusive, clock, reset, rsp_valid_ff,
                    !(rsp_fwd_ff && rsp_bwd_ff))
   `DDTC_ASSERT_NOW(a_limit_zero_drive, clock, reset, rsp_valid_ff && rsp_limited_ff,
                    rsp_drive_ff == '0)
   `DDTC_ASSERT_NOW(a_pulse_clamped, clock, reset, rsp_valid_ff,
                    rsp_pulse_ff <= pulse_max_ff)
   `DDTC_ASSERT_NEXT(a_step_fills_rsp, clock, reset, step, rsp_valid_ff)

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the drive direction and throttle control block.
// Depends on ddtc_pkg, the ddtc_req_if/ddtc_rsp_if interfaces and the top level RTL.
module testbench import ddtc_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          SAMPLE_BITS = 12;
   localparam int unsigned SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] throttle_a;
      logic [SAMPLE_BITS-1:0] throttle_b;
      logic                   fwd_switch;
      logic                   bwd_switch;
      logic                   frame_valid;
      logic [10:0]            frame_id;
      logic [7:0]             frame_byte0;
      logic [7:0]             frame_byte1;
   } tick_word_type;

   typedef struct packed {
      logic        fwd_drive_en;
      logic        rev_drive_en;
      logic [11:0] pulse_width_us;
      logic [11:0] motor_drive;
      logic        rev_limited;
   } control_word_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   ddtc_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   ddtc_rsp_if rsp_bus ();

   drive_direction_throttle_ctrl #(.SAMPLE_BITS(SAMPLE_BITS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register copy and control state of the predictor.
   logic [15:0] cfg_rev_limit;
   logic [10:0] cfg_rpm_id;
   logic [11:0] cfg_ramp_step;
   logic [11:0] cfg_pulse_offset;
   logic [11:0] cfg_pulse_max;
   logic [7:0]  cfg_debounce;

   logic        heading_fwd, heading_rev;
   logic        fwd_wait_release, bwd_wait_release;
   logic        fwd_armed, bwd_armed;
   logic [7:0]  fwd_press_count, bwd_press_count;
   logic [11:0] drive_level;

   control_word_type awaited_controls[$];
   bit               failed = 1'b0;
   bit               sender_gaps = 1'b1;
   bit               sink_stalls = 1'b1;
   int               hold_off_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic void reset_predictor();
      cfg_rev_limit    = REV_LIMIT_RESET;
      cfg_rpm_id       = RPM_MESSAGE_ID_RESET;
      cfg_ramp_step    = RAMP_STEP_RESET;
      cfg_pulse_offset = PULSE_OFFSET_RESET;
      cfg_pulse_max    = PULSE_MAX_RESET;
      cfg_debounce     = DEBOUNCE_TICKS_RESET;
      heading_fwd      = 1'b0;
      heading_rev      = 1'b0;
      fwd_wait_release = 1'b1;
      bwd_wait_release = 1'b1;
      fwd_armed        = 1'b0;
      bwd_armed        = 1'b0;
      fwd_press_count  = '0;
      bwd_press_count  = '0;
      drive_level      = '0;
   endfunction

   // Advances the control state by one tick and returns the word it should produce.
   function automatic control_word_type predict_controls(input tick_word_type w);
      control_word_type r;
      logic [12:0]      sum;
      logic [12:0]      next_level;
      logic [11:0]      avg;
      logic [15:0]      rpm;
      int unsigned      pulse;
      logic             was_off;
      logic             limited;
      r = '0;
      if (fwd_wait_release) begin
         if (!w.fwd_switch) begin
            fwd_armed = 1'b1;
            fwd_wait_release = 1'b0;
         end
      end else if (bwd_wait_release) begin
         if (!w.bwd_switch) begin
            bwd_armed = 1'b1;
            bwd_wait_release = 1'b0;
         end
      end

      // The enables reflect the direction held before this tick's toggle.
      if (heading_fwd && !heading_rev) r.fwd_drive_en = 1'b1;
      else if (heading_rev && !heading_fwd) r.rev_drive_en = 1'b1;

      was_off = !heading_fwd && !heading_rev;
      if (w.fwd_switch) begin
         bwd_press_count = '0;
         if (fwd_press_count != COUNT_MAX) fwd_press_count = fwd_press_count + 8'd1;
         fwd_wait_release = 1'b1;
         if (fwd_armed && fwd_press_count > cfg_debounce && !(heading_fwd && heading_rev)) begin
            heading_fwd = was_off;
            heading_rev = 1'b0;
            fwd_armed = 1'b0;
         end
      end else if (w.bwd_switch) begin
         fwd_press_count = '0;
         if (bwd_press_count != COUNT_MAX) bwd_press_count = bwd_press_count + 8'd1;
         bwd_wait_release = 1'b1;
         if (bwd_armed && bwd_press_count > cfg_debounce && !(heading_fwd && heading_rev)) begin
            heading_fwd = 1'b0;
            heading_rev = was_off;
            bwd_armed = 1'b0;
         end
      end else begin
         fwd_press_count = '0;
         bwd_press_count = '0;
      end

      sum = {1'b0, w.throttle_a} + {1'b0, w.throttle_b};
      pulse = 32'(cfg_pulse_offset) + (32'd1000 * 32'(sum)) / SAMPLE_MAX;
      if (pulse > 32'(cfg_pulse_max)) pulse = 32'(cfg_pulse_max);
      r.pulse_width_us = pulse[11:0];

      avg = sum[12:1];
      rpm = {w.frame_byte1, w.frame_byte0};
      limited = w.frame_valid && w.frame_id == cfg_rpm_id && rpm >= cfg_rev_limit;
      if (limited) begin
         r.motor_drive = '0;
      end else if (avg > drive_level) begin
         next_level = {1'b0, drive_level} + {1'b0, cfg_ramp_step};
         if (next_level > {1'b0, LEVEL_MAX}) drive_level = LEVEL_MAX;
         else drive_level = next_level[11:0];
         r.motor_drive = drive_level;
      end else begin
         drive_level = avg;
         r.motor_drive = avg;
      end
      r.rev_limited = limited;
      return r;
   endfunction

   // Response side: random stalls, plus a long hold-off on request.
   initial begin
      rsp_bus.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
            rsp_bus.ready = 1'b1;
         end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
            rsp_bus.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      control_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_controls.size() == 0) begin
            $error("response word arrived with none expected");
            failed = 1'b1;
         end else begin
            want = awaited_controls.pop_front();
            if (rsp_bus.fwd_drive_en !== want.fwd_drive_en) begin
               $error("fwd_drive_en: expected %0d, got %0d", want.fwd_drive_en,
                      rsp_bus.fwd_drive_en);
               failed = 1'b1;
            end
            if (rsp_bus.rev_drive_en !== want.rev_drive_en) begin
               $error("rev_drive_en: expected %0d, got %0d", want.rev_drive_en,
                      rsp_bus.rev_drive_en);
               failed = 1'b1;
            end
            if (rsp_bus.pulse_width_us !== want.pulse_width_us) begin
               $error("pulse_width_us: expected %0d, got %0d", want.pulse_width_us,
                      rsp_bus.pulse_width_us);
               failed = 1'b1;
            end
            if (rsp_bus.motor_drive !== want.motor_drive) begin
               $error("motor_drive: expected %0d, got %0d", want.motor_drive,
                      rsp_bus.motor_drive);
               failed = 1'b1;
            end
            if (rsp_bus.rev_limited !== want.rev_limited) begin
               $error("rev_limited: expected %0d, got %0d", want.rev_limited,
                      rsp_bus.rev_limited);
               failed = 1'b1;
            end
         end
      end
   end

   // Offers one word, optionally after a short gap, and records its expected response.
   task automatic send_word(input tick_word_type w);
      int gap;
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.throttle_a  = w.throttle_a;
      req_bus.throttle_b  = w.throttle_b;
      req_bus.fwd_switch  = w.fwd_switch;
      req_bus.bwd_switch  = w.bwd_switch;
      req_bus.frame_valid = w.frame_valid;
      req_bus.frame_id    = w.frame_id;
      req_bus.frame_byte0 = w.frame_byte0;
      req_bus.frame_byte1 = w.frame_byte1;
      req_bus.valid       = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      awaited_controls.push_back(predict_controls(w));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (awaited_controls.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         REG_REV_LIMIT:      cfg_rev_limit    = data;
         REG_RPM_MESSAGE_ID: cfg_rpm_id       = data[10:0];
         REG_RAMP_STEP:      cfg_ramp_step    = data[11:0];
         REG_PULSE_OFFSET:   cfg_pulse_offset = data[11:0];
         REG_PULSE_MAX:      cfg_pulse_max    = data[11:0];
         REG_DEBOUNCE_TICKS: cfg_debounce     = data[7:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [15:0] rev, input logic [10:0] id,
                                 input logic [11:0] step, input logic [11:0] offset,
                                 input logic [11:0] pmax, input logic [7:0] deb);
      wait_drained();
      write_reg(REG_REV_LIMIT, rev);
      write_reg(REG_RPM_MESSAGE_ID, 16'(id));
      write_reg(REG_RAMP_STEP, 16'(step));
      write_reg(REG_PULSE_OFFSET, 16'(offset));
      write_reg(REG_PULSE_MAX, 16'(pmax));
      write_reg(REG_DEBOUNCE_TICKS, 16'(deb));
   endtask

   function automatic tick_word_type make_word(input logic [11:0] a, input logic [11:0] b,
                                               input bit f, input bit bw, input bit fv,
                                               input logic [10:0] id, input logic [15:0] rpm);
      tick_word_type w;
      w.throttle_a  = a;
      w.throttle_b  = b;
      w.fwd_switch  = f;
      w.bwd_switch  = bw;
      w.frame_valid = fv;
      w.frame_id    = id;
      w.frame_byte0 = rpm[7:0];
      w.frame_byte1 = rpm[15:8];
      return w;
   endfunction

   function automatic logic [11:0] pick_sample();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return 12'd0;
      if (k == 1) return 12'hFFF;
      return 12'($urandom_range(0, 4095));
   endfunction

   // Random frame content, biased toward the rpm identifier and the limit.
   function automatic tick_word_type random_word(input bit f, input bit bw,
                                                 input logic [11:0] a, input logic [11:0] b);
      int   k;
      int   near;
      bit   fv;
      logic [10:0] id;
      logic [15:0] rpm;
      k = $urandom_range(0, 5);
      fv = (k >= 2);
      id = 11'($urandom_range(0, 2047));
      rpm = 16'($urandom_range(0, 65535));
      if (k >= 3) id = cfg_rpm_id;
      if (k == 3 || k == 4) begin
         near = int'(cfg_rev_limit) + int'($urandom_range(0, 4)) - 2;
         if (near < 0) near = 0;
         if (near > 65535) near = 65535;
         rpm = 16'(near);
      end
      return make_word(a, b, f, bw, fv, id, rpm);
   endfunction

   // Switch press and release patterns with random throttle and frames.
   task automatic run_presses(input int ticks);
      int   left, hold_len, rest_len, kind, n;
      bit   steady, f, bw;
      logic [11:0] a, b;
      left = ticks;
      while (left > 0) begin
         kind = $urandom_range(0, 9);
         hold_len = $urandom_range(1, 7);
         rest_len = $urandom_range(1, 3);
         steady = 1'($urandom_range(0, 1));
         a = pick_sample();
         b = pick_sample();
         for (n = 0; n < hold_len + rest_len && left > 0; n++) begin
            if (!steady) begin
               a = pick_sample();
               b = pick_sample();
            end
            if (kind == 9) begin
               f = 1'($urandom_range(0, 1));
               bw = 1'($urandom_range(0, 1));
            end else if (n < hold_len) begin
               f = (kind <= 3) || (kind == 8);
               bw = (kind >= 4);
            end else begin
               f = 1'b0;
               bw = 1'b0;
            end
            send_word(random_word(f, bw, a, b));
            left--;
         end
      end
   endtask

   task automatic test_directed();
      send_word(make_word(12'd0, 12'd0, 1'b0, 1'b0, 1'b0, 11'd0, 16'd0));
      send_word(make_word(12'hFFF, 12'hFFF, 1'b0, 1'b0, 1'b0, 11'd0, 16'd0));
      // A frame that is not marked valid must not limit, whatever it carries.
      send_word(make_word(12'd0, 12'hFFF, 1'b0, 1'b0, 1'b0, RPM_MESSAGE_ID_RESET,
                          16'hFFFF));
      send_word(make_word(12'hFFF, 12'd0, 1'b0, 1'b0, 1'b1, 11'h611, 16'hFFFF));
      send_word(make_word(12'd2048, 12'd2047, 1'b0, 1'b0, 1'b1, RPM_MESSAGE_ID_RESET,
                          16'd4999));
      send_word(make_word(12'd2048, 12'd2047, 1'b0, 1'b0, 1'b1, RPM_MESSAGE_ID_RESET,
                          16'd5000));
      // A high byte above 127 still reads as a large rpm.
      send_word(make_word(12'hFFF, 12'hFFF, 1'b0, 1'b0, 1'b1, RPM_MESSAGE_ID_RESET,
                          16'hFF00));
      repeat (5) send_word(make_word(12'd1000, 12'd1500, 1'b1, 1'b0, 1'b0, 11'h7FF, 16'd0));
      send_word(make_word(12'd1, 12'd2, 1'b0, 1'b0, 1'b0, 11'd0, 16'd0));
      send_word(make_word(12'd3000, 12'd100, 1'b1, 1'b1, 1'b0, 11'd0, 16'd0));
      repeat (3) send_word(make_word(12'd3000, 12'd100, 1'b1, 1'b0, 1'b0, 11'd0, 16'd0));
      send_word(make_word(12'd50, 12'd60, 1'b0, 1'b0, 1'b0, 11'd0, 16'd0));
      repeat (5) send_word(make_word(12'd800, 12'd4095, 1'b0, 1'b1, 1'b0, 11'd0, 16'd0));
      send_word(make_word(12'd0, 12'd0, 1'b0, 1'b0, 1'b0, 11'd0, 16'd0));
   endtask

   task automatic test_toggle_sequences();
      run_presses(160);
   endtask

   task automatic test_register_sweep();
      apply_settings(16'd0, 11'd0, 12'd0, 12'd0, 12'd0, 8'd0);
      run_presses(90);
      apply_settings(16'hFFFF, 11'h7FF, 12'hFFF, 12'hFFF, 12'hFFF, 8'hFF);
      run_presses(90);
      // Small clamp and a full-scale step, so the ramp saturates.
      apply_settings(16'd3000, 11'h2AA, 12'hFFF, 12'd1000, 12'd1200, 8'd1);
      run_presses(90);
      repeat (2) begin
         apply_settings(16'($urandom_range(0, 65535)), 11'($urandom_range(0, 2047)),
                        12'($urandom_range(1, 400)), 12'($urandom_range(0, 2000)),
                        12'($urandom_range(1000, 4095)), 8'($urandom_range(0, 6)));
         run_presses(90);
      end
      apply_settings(REV_LIMIT_RESET, RPM_MESSAGE_ID_RESET, RAMP_STEP_RESET,
                     PULSE_OFFSET_RESET, PULSE_MAX_RESET, DEBOUNCE_TICKS_RESET);
      run_presses(90);
   endtask

   // Long presses drive the forward count into saturation; at 255 it can never
   // exceed the threshold, at 254 it toggles once saturated.
   task automatic test_counter_saturation();
      int thr;
      for (thr = 255; thr >= 254; thr--) begin
         wait_drained();
         write_reg(REG_DEBOUNCE_TICKS, 16'(thr));
         send_word(random_word(1'b0, 1'b0, pick_sample(), pick_sample()));
         repeat (262) send_word(random_word(1'b1, 1'b0, pick_sample(), pick_sample()));
         send_word(random_word(1'b0, 1'b0, pick_sample(), pick_sample()));
      end
      wait_drained();
      write_reg(REG_DEBOUNCE_TICKS, 16'(DEBOUNCE_TICKS_RESET));
   endtask

   task automatic test_output_backpressure();
      hold_off_cycles = 120;
      run_presses(40);
      wait_drained();
   endtask

   task automatic test_input_pause();
      run_presses(30);
      wait_drained();
      run_presses(30);
   endtask

   task automatic test_steady_stream();
      sender_gaps = 1'b0;
      sink_stalls = 1'b0;
      run_presses(100);
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = REG_REV_LIMIT;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.throttle_a = '0;
      req_bus.throttle_b = '0;
      req_bus.fwd_switch = 1'b0;
      req_bus.bwd_switch = 1'b0;
      req_bus.frame_valid = 1'b0;
      req_bus.frame_id = '0;
      req_bus.frame_byte0 = '0;
      req_bus.frame_byte1 = '0;
      reset_predictor();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_toggle_sequences();
      test_register_sweep();
      test_counter_saturation();
      test_output_backpressure();
      test_input_pause();
      test_steady_stream();

      wait_drained();
      repeat (8) @(posedge clock);
      if (!failed) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
